/* rtl/core/sssk_pkg.sv */
// Shared types, constants and font tables for the seven-segment scan core.
// No dependencies; used by the channel interfaces and the core.

package sssk_pkg;

   localparam int TICKS_PER_KEY_STEP = 8;
   localparam int DIGIT_COUNT        = 6;

   localparam int DIV_W   = (TICKS_PER_KEY_STEP > 1) ? $clog2(TICKS_PER_KEY_STEP) : 1;
   localparam int POS_W   = $clog2(DIGIT_COUNT);
   localparam int CODES_W = 4 * DIGIT_COUNT;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);
   localparam logic [POS_W-1:0] TEMP_POS = POS_W'(3);

   // Blink masks on the common lines, one per cursor field
   localparam logic [DIGIT_COUNT-1:0] BLINK_SECONDS = 6'h30;
   localparam logic [DIGIT_COUNT-1:0] BLINK_MINUTES = 6'h0C;
   localparam logic [DIGIT_COUNT-1:0] BLINK_HOURS   = 6'h03;
   localparam logic [DIGIT_COUNT-1:0] BLINK_FORMAT  = 6'h07;

   typedef enum logic [1:0] {
      CMD_SCAN_TICK    = 2'd0,
      CMD_SECOND_PULSE = 2'd1,
      CMD_LOAD_TIMEOUT = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      CUR_SECONDS = 2'd0,
      CUR_MINUTES = 2'd1,
      CUR_HOURS   = 2'd2,
      CUR_FORMAT  = 2'd3
   } cursor_type;

   typedef struct packed {
      logic [1:0]         command;
      logic               set_key_level;
      logic               up_key_level;
      logic               square_wave;
      logic [CODES_W-1:0] digit_codes;
      logic               hour12_mode;
      logic               pm_flag;
      logic               display_enable;
      logic               show_temperature;
      logic               menu_active;
      logic [1:0]         cursor_position;
      logic [7:0]         timeout_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             segments;
      logic [DIGIT_COUNT-1:0] commons;
      logic                   point_led;
      logic [7:0]             set_hold_count;
      logic [7:0]             up_hold_count;
      logic                   read_request;
      logic                   timeout_expired;
   } rsp_payload_type;

   // Numeral font for digits 0..9 and codes 11..13 (common anode)
   function automatic logic [7:0] digit_font(input logic [3:0] code);
      logic [7:0] seg;
      case (code)
         4'd0:    seg = 8'h7E;
         4'd1:    seg = 8'h0C;
         4'd2:    seg = 8'hB6;
         4'd3:    seg = 8'h9E;
         4'd4:    seg = 8'hCC;
         4'd5:    seg = 8'hDA;
         4'd6:    seg = 8'hFA;
         4'd7:    seg = 8'h0E;
         4'd8:    seg = 8'hFE;
         4'd9:    seg = 8'hDE;
         4'd11:   seg = 8'hEC;
         4'd12:   seg = 8'h80;
         4'd13:   seg = 8'h72;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // Leading digit shows only blank, one or two
   function automatic logic [7:0] lead_font(input logic [3:0] code);
      logic [7:0] seg;
      case (code)
         4'd1:    seg = 8'h0C;
         4'd2:    seg = 8'hB6;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

/* rtl/core/sssk_channels.sv */
// Valid/ready channel interfaces for the request and response streams.
// Depends on sssk_pkg for the payload types.

interface sssk_req_if;
   logic                      valid;
   logic                      ready;
   sssk_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sssk_rsp_if;
   logic                      valid;
   logic                      ready;
   sssk_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/seven_segment_scan_with_key_timers_core.sv */
// Six-digit display scan core with key-hold timers and a timeout counter.
// Response valid rises in the cycle after the request transfer (output register).
// Throughput: one request per cycle; the request side stalls only while a
// response sits in the output register and the response side is not ready.
// Reset (synchronous, active high) clears scan position, divider, hold
// counters, colon and timeout, and empties the output register.

module seven_segment_scan_with_key_timers_core (
   input  logic             clock,
   input  logic             reset,
   sssk_req_if.sink         req_chan,
   sssk_rsp_if.source       rsp_chan
);
   import sssk_pkg::*;

   logic [POS_W-1:0]       scan_pos_ff, scan_pos_in;
   logic [DIV_W-1:0]       tick_div_ff, tick_div_in;
   logic [7:0]             set_hold_ff, set_hold_in;
   logic [7:0]             up_hold_ff, up_hold_in;
   logic                   colon_ff, colon_in;
   logic [7:0]             timeout_ff, timeout_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [DIV_W:0]         div_inc;
   logic                   key_step;
   logic [3:0]             code;
   logic [DIGIT_COUNT-1:0] blink_mask;
   logic [DIGIT_COUNT-1:0] common_sel;
   req_payload_type        req;

   assign req      = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      scan_pos_in = scan_pos_ff;
      tick_div_in = tick_div_ff;
      set_hold_in = set_hold_ff;
      up_hold_in  = up_hold_ff;
      colon_in    = colon_ff;
      timeout_in  = timeout_ff;

      div_inc    = {1'b0, tick_div_ff} + 1'b1;
      key_step   = (div_inc >= (DIV_W + 1)'(TICKS_PER_KEY_STEP));
      code       = '0;
      blink_mask = '0;
      common_sel = '0;

      rsp_data_in                 = '0;
      rsp_data_in.set_hold_count  = set_hold_ff;
      rsp_data_in.up_hold_count   = up_hold_ff;

      case (req.command)
         CMD_SCAN_TICK: begin
            // Divider and key hold counters
            if (key_step) begin
               tick_div_in = '0;
               if (set_hold_ff != 8'hFF) set_hold_in = set_hold_ff + 8'd1;
               if (up_hold_ff != 8'hFF) up_hold_in = up_hold_ff + 8'd1;
               if (req.set_key_level) set_hold_in = '0;
               if (req.up_key_level) up_hold_in = '0;
            end else begin
               tick_div_in = div_inc[DIV_W-1:0];
            end

            // Advance to next digit, wrap after the last
            scan_pos_in = (scan_pos_ff == LAST_POS) ? '0 : scan_pos_ff + 1'b1;
            code = req.digit_codes[4*scan_pos_in +: 4];

            if (scan_pos_in == '0) begin
               rsp_data_in.segments  = lead_font(code);
               rsp_data_in.point_led = req.hour12_mode && !req.pm_flag;
            end else if (scan_pos_in == LAST_POS) begin
               rsp_data_in.segments  = digit_font(code);
               rsp_data_in.point_led = req.hour12_mode && req.pm_flag;
            end else begin
               rsp_data_in.segments  = digit_font(code);
               rsp_data_in.point_led = colon_ff ||
                                       (scan_pos_in == TEMP_POS && req.show_temperature);
            end

            common_sel = DIGIT_COUNT'(1) << scan_pos_in;

            if (req.menu_active && req.square_wave) begin
               case (req.cursor_position)
                  CUR_SECONDS: blink_mask = BLINK_SECONDS;
                  CUR_MINUTES: blink_mask = BLINK_MINUTES;
                  CUR_HOURS:   blink_mask = BLINK_HOURS;
                  CUR_FORMAT:  blink_mask = BLINK_FORMAT;
                  default:     blink_mask = '0;
               endcase
            end
            rsp_data_in.commons = req.display_enable ? (common_sel & ~blink_mask) : '0;

            // Colon for the next pass
            if (!req.show_temperature) colon_in = 1'b1;
            if (req.menu_active && req.cursor_position == CUR_FORMAT) colon_in = 1'b0;
            if (req.square_wave) colon_in = 1'b0;

            rsp_data_in.set_hold_count = set_hold_in;
            rsp_data_in.up_hold_count  = up_hold_in;
         end
         CMD_SECOND_PULSE: begin
            if (timeout_ff != '0) begin
               timeout_in = timeout_ff - 8'd1;
               rsp_data_in.timeout_expired = (timeout_ff == 8'd1);
            end
            rsp_data_in.read_request = 1'b1;
         end
         CMD_LOAD_TIMEOUT: begin
            timeout_in = req.timeout_value;
         end
         default: begin
         end
      endcase

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff  <= '0;
         tick_div_ff  <= '0;
         set_hold_ff  <= '0;
         up_hold_ff   <= '0;
         colon_ff     <= 1'b0;
         timeout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            scan_pos_ff <= scan_pos_in;
            tick_div_ff <= tick_div_in;
            set_hold_ff <= set_hold_in;
            up_hold_ff  <= up_hold_in;
            colon_ff    <= colon_in;
            timeout_ff  <= timeout_in;
         end
      end
   end

   // Output data holds until the next transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for the seven-segment scan core: directed table, key-hold soak, random run.
// Needs sssk_pkg, the sssk_req_if / sssk_rsp_if channels and the core RTL.
`timescale 1ns / 100ps

module tb_top;
   import sssk_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         DIRECTED_ROWS = 25;
   localparam int         RANDOM_ITEMS  = 625;
   localparam int         SOAK_TICKS    = 200;
   localparam int         MAX_WAIT      = 12;

   // Segment fonts, indexed by digit code
   localparam logic [15:0][7:0] NUMERAL_SEGS = {
      8'h00, 8'h00, 8'h72, 8'h80, 8'hEC, 8'h00, 8'hDE, 8'hFE,
      8'h0E, 8'hFA, 8'hDA, 8'hCC, 8'h9E, 8'hB6, 8'h0C, 8'h7E};
   localparam logic [15:0][7:0] LEAD_SEGS = {{13{8'h00}}, 8'hB6, 8'h0C, 8'h00};

   localparam rsp_payload_type NO_RSP = '0;

   typedef struct {
      req_payload_type stim;
      bit              typed;
      rsp_payload_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   sssk_req_if req_chan ();
   sssk_rsp_if rsp_chan ();

   seven_segment_scan_with_key_timers_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state
   logic [POS_W-1:0] scan_pos;
   int               key_div;
   logic [7:0]       set_hold;
   logic [7:0]       up_hold;
   logic             colon_lit;
   logic [7:0]       secs_left;

   rsp_payload_type expected_reports [$];
   int              mismatch_count;
   bit              no_idle;

   // Random stimulus runs: keys, square wave and menu change slowly
   logic       set_run;
   logic       up_run;
   logic       square_run;
   logic       menu_run;
   logic [1:0] cursor_run;

   stim_row_type directed [DIRECTED_ROWS] = '{
      '{'{CMD_SECOND_PULSE, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
      '{'{CMD_LOAD_TIMEOUT, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd1}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{CMD_SECOND_PULSE, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
      '{'{CMD_SECOND_PULSE, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
      '{'{CMD_UNUSED, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
          CUR_FORMAT, 8'hFF}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{CMD_LOAD_TIMEOUT, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'hFF}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{CMD_SECOND_PULSE, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
      '{'{CMD_LOAD_TIMEOUT, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{CMD_SECOND_PULSE, 1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b1, '{8'h00, 6'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}},
      // Scan ticks from here on: set key held, up key released until the last three rows
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'h012345, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'h6789AB, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'hCDEF01, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'hFEDCBA, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'h987654, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'h3210F2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'hFFFFF1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b1, 24'h543210, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b1, 24'hABCDEF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_MINUTES, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b1, 24'h13579B, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_HOURS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b0, 24'h2468AC, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_FORMAT, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b1, 24'hDB9752, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_FORMAT, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b1, 1'b1, 24'h111111, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_HOURS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b0, 1'b1, 24'h222222, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
          CUR_FORMAT, 8'hFF}, 1'b0, NO_RSP},
      '{'{CMD_SCAN_TICK, 1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          CUR_SECONDS, 8'd0}, 1'b0, NO_RSP}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Advance the predictor by one request and return the report it should produce
   function automatic rsp_payload_type predict_report(input req_payload_type r);
      rsp_payload_type  rep;
      logic [3:0]       code;
      logic [5:0]       blink;
      rep   = '0;
      blink = '0;
      case (r.command)
         CMD_SCAN_TICK: begin
            key_div++;
            if (key_div >= TICKS_PER_KEY_STEP) begin
               key_div = 0;
               if (set_hold != 8'hFF) set_hold++;
               if (up_hold != 8'hFF) up_hold++;
               if (r.set_key_level) set_hold = '0;
               if (r.up_key_level) up_hold = '0;
            end
            scan_pos = (scan_pos == LAST_POS) ? '0 : scan_pos + 1'b1;
            code = r.digit_codes[4*scan_pos +: 4];
            if (scan_pos == '0) begin
               rep.segments  = LEAD_SEGS[code];
               rep.point_led = r.hour12_mode & ~r.pm_flag;
            end else if (scan_pos == LAST_POS) begin
               rep.segments  = NUMERAL_SEGS[code];
               rep.point_led = r.hour12_mode & r.pm_flag;
            end else begin
               rep.segments  = NUMERAL_SEGS[code];
               // colon lamp shows the value from before this tick
               rep.point_led = colon_lit | ((scan_pos == TEMP_POS) & r.show_temperature);
            end
            rep.commons = r.display_enable ? (6'd1 << scan_pos) : 6'd0;
            if (!r.show_temperature) colon_lit = 1'b1;
            if (r.menu_active) begin
               if (r.square_wave) begin
                  case (r.cursor_position)
                     CUR_SECONDS: blink = BLINK_SECONDS;
                     CUR_MINUTES: blink = BLINK_MINUTES;
                     CUR_HOURS:   blink = BLINK_HOURS;
                     default:     blink = BLINK_FORMAT;
                  endcase
               end
               if (r.cursor_position == CUR_FORMAT) colon_lit = 1'b0;
            end
            if (r.square_wave) colon_lit = 1'b0;
            rep.commons &= ~blink;
         end
         CMD_SECOND_PULSE: begin
            if (secs_left != '0) begin
               secs_left--;
               rep.timeout_expired = (secs_left == '0);
            end
            rep.read_request = 1'b1;
         end
         CMD_LOAD_TIMEOUT: secs_left = r.timeout_value;
         default: ;
      endcase
      rep.set_hold_count = set_hold;
      rep.up_hold_count  = up_hold;
      return rep;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int              pick;
      r    = '0;
      pick = $urandom_range(0, 99);
      if (pick < 68)      r.command = CMD_SCAN_TICK;
      else if (pick < 86) r.command = CMD_SECOND_PULSE;
      else if (pick < 96) r.command = CMD_LOAD_TIMEOUT;
      else                r.command = CMD_UNUSED;
      if ($urandom_range(0, 29) == 0) set_run = ~set_run;
      if ($urandom_range(0, 29) == 0) up_run = ~up_run;
      if ($urandom_range(0, 9) == 0) square_run = ~square_run;
      if ($urandom_range(0, 19) == 0) begin
         menu_run   = ~menu_run;
         cursor_run = 2'($urandom_range(0, 3));
      end
      r.set_key_level    = set_run;
      r.up_key_level     = up_run;
      r.square_wave      = square_run;
      r.digit_codes      = 24'($urandom());
      r.hour12_mode      = 1'($urandom_range(0, 1));
      r.pm_flag          = 1'($urandom_range(0, 1));
      r.display_enable   = ($urandom_range(0, 7) != 0);
      r.show_temperature = ($urandom_range(0, 3) == 0);
      r.menu_active      = menu_run;
      r.cursor_position  = cursor_run;
      // mostly short timeouts so expiry comes around often
      r.timeout_value    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 4));
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [23:0] got,
                              input logic [23:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", field, got, want));
   endtask

   // Hold valid high until the core takes the request, then log its expected report
   task automatic send_request(input req_payload_type stim, input bit typed,
                               input rsp_payload_type want);
      int              gap;
      rsp_payload_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= stim;
      do @(posedge clock); while (!req_chan.ready);
      predicted = predict_report(stim);
      expected_reports.push_back(typed ? want : predicted);
   endtask

   task automatic drain_reports();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   initial begin : request_driver
      req_payload_type r;
      scan_pos       = '0;
      key_div        = 0;
      set_hold       = '0;
      up_hold        = '0;
      colon_lit      = 1'b0;
      secs_left      = '0;
      mismatch_count = 0;
      no_idle        = 1'b0;
      set_run        = 1'b1;
      up_run         = 1'b1;
      square_run     = 1'b0;
      menu_run       = 1'b0;
      cursor_run     = CUR_SECONDS;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i].stim, directed[i].typed, directed[i].want);
      drain_reports();

      // Hold both keys down for a long run of back-to-back ticks
      no_idle = 1'b1;
      repeat (SOAK_TICKS) begin
         r = random_request();
         r.command       = CMD_SCAN_TICK;
         r.set_key_level = 1'b0;
         r.up_key_level  = 1'b0;
         send_request(r, 1'b0, NO_RSP);
      end
      set_run = 1'b0;
      up_run  = 1'b0;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = ((i % 200) >= 160);
         if (i == RANDOM_ITEMS / 2) drain_reports();
         send_request(random_request(), 1'b0, NO_RSP);
      end
      no_idle = 1'b0;

      drain_reports();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : rsp_pacer
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin : report_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_reports.size() == 0) begin
            report_mismatch("report transfer with no request outstanding");
         end else begin
            want = expected_reports.pop_front();
            check_field("segments", 24'(got.segments), 24'(want.segments));
            check_field("commons", 24'(got.commons), 24'(want.commons));
            check_field("point_led", 24'(got.point_led), 24'(want.point_led));
            check_field("set_hold_count", 24'(got.set_hold_count),
                        24'(want.set_hold_count));
            check_field("up_hold_count", 24'(got.up_hold_count), 24'(want.up_hold_count));
            check_field("read_request", 24'(got.read_request), 24'(want.read_request));
            check_field("timeout_expired", 24'(got.timeout_expired),
                        24'(want.timeout_expired));
         end
      end
   end

endmodule

/* files.f */
rtl/core/sssk_pkg.sv
rtl/core/sssk_channels.sv
rtl/core/seven_segment_scan_with_key_timers_core.sv
tb/sv/tb_top.sv
